/* rtl/multiport_latency_memory_top_defines.svh */
// assertion macros for the multiport latency memory
`ifndef MULTIPORT_LATENCY_MEMORY_TOP_DEFINES_SVH
`define MULTIPORT_LATENCY_MEMORY_TOP_DEFINES_SVH

// condition must never hold outside reset
`define MLM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define MLM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/mlm_pkg.sv */
// shared types and constants of the multiport latency memory
`timescale 1ns / 1ps
package mlm_pkg;

    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 5;
    localparam int LAT_W  = 5;
    localparam int PC_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_READ   = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_CANCEL = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_READ = 2'd0,
        ST_WACK = 2'd1,
        ST_DROP = 2'd2
    } t_status;

    typedef enum logic {
        CFG_LATENCY    = 1'b0,
        CFG_PORT_COUNT = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SERVE,
        S_SERVE_DATA,
        S_DROP,
        S_TSCAN,
        S_QWAIT,
        S_QCHECK,
        S_CSCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic       busy;
        logic [3:0] pend_count;
        logic [6:0] queue_count;
        logic [3:0] free_ports;
    } t_back_stat;

endpackage

/* rtl/mlm_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/mlm_front.sv */
// front end: request intake, command decode and two entry queue to the engine
`timescale 1ns / 1ps
module mlm_front #(
    parameter int TAG_BITS  = 8,
    parameter int ADDR_BITS = 10,
    parameter int WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [mlm_pkg::CMD_W-1:0]  i_cmd,
    input  logic [TAG_BITS-1:0]        i_tag,
    input  logic [ADDR_BITS-1:0]       i_addr,
    input  logic [WORD_BITS-1:0]       i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output mlm_pkg::t_cmd              o_cmd,
    output logic [TAG_BITS-1:0]        o_tag,
    output logic [ADDR_BITS-1:0]       o_addr,
    output logic [WORD_BITS-1:0]       o_data
);

    localparam int EW = mlm_pkg::CMD_W + TAG_BITS + ADDR_BITS + WORD_BITS;

    logic [EW-1:0] r_buf [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;
    logic          n_wptr;
    logic          n_rptr;
    logic [1:0]    n_cnt;
    logic          push;
    logic          pop;
    logic [EW-1:0] head;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign head    = r_buf[r_rptr];
    assign o_cmd   = mlm_pkg::t_cmd'(head[mlm_pkg::CMD_W-1:0]);
    assign o_tag   = head[mlm_pkg::CMD_W +: TAG_BITS];
    assign o_addr  = head[mlm_pkg::CMD_W + TAG_BITS +: ADDR_BITS];
    assign o_data  = head[mlm_pkg::CMD_W + TAG_BITS + ADDR_BITS +: WORD_BITS];

    always_comb begin
        n_wptr = push ? !r_wptr : r_wptr;
        n_rptr = pop ? !r_rptr : r_rptr;
        n_cnt  = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= {i_data, i_addr, i_tag, i_cmd};
        end
    end

endmodule

/* rtl/mlm_back.sv */
// back end: port bookkeeping, pending list, wait queue, word store and result output
`timescale 1ns / 1ps
module mlm_back #(
    parameter int PORTS       = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ADDR_BITS   = 10,
    parameter int WORD_BITS   = 32,
    parameter int TAG_BITS    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [mlm_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  mlm_pkg::t_cmd              i_cmd,
    input  logic [TAG_BITS-1:0]        i_tag,
    input  logic [ADDR_BITS-1:0]       i_addr,
    input  logic [WORD_BITS-1:0]       i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [TAG_BITS-1:0]        o_tag,
    output mlm_pkg::t_status           o_status,
    output logic [WORD_BITS-1:0]       o_data,
    output logic                       o_last,
    output mlm_pkg::t_back_stat        o_stat
);

    localparam int CNT_W  = $clog2(PORTS + 1);
    localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int QE_W   = 1 + ADDR_BITS + WORD_BITS + TAG_BITS;
    localparam int LW     = mlm_pkg::LAT_W;

    mlm_pkg::t_state r_state, n_state, r_ret, n_ret;

    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [TAG_BITS-1:0]  r_srv_tag, n_srv_tag;
    logic                 r_srv_wr, n_srv_wr;
    logic [ADDR_BITS-1:0] r_srv_addr, n_srv_addr;
    logic [WORD_BITS-1:0] r_srv_data, n_srv_data;
    logic [CNT_W-1:0]     r_ret_ports, n_ret_ports;
    logic [CNT_W-1:0]     r_free, n_free;
    logic [CNT_W-1:0]     r_freed, n_freed;
    logic [LW-1:0]        r_lat, n_lat;
    logic [CNT_W-1:0]     r_pcnt, n_pcnt;
    logic [QA_W-1:0]      r_qhead, n_qhead;
    logic [QA_W-1:0]      r_qtail, n_qtail;
    logic [QC_W-1:0]      r_qcnt, n_qcnt;

    logic                      r_hold_v, n_hold_v;
    logic [TAG_BITS-1:0]       r_hold_tag, n_hold_tag;
    mlm_pkg::t_status          r_hold_status, n_hold_status;
    logic [WORD_BITS-1:0]      r_hold_data, n_hold_data;
    logic                      r_out_v, n_out_v;
    logic [TAG_BITS-1:0]       r_out_tag, n_out_tag;
    mlm_pkg::t_status          r_out_status, n_out_status;
    logic [WORD_BITS-1:0]      r_out_data, n_out_data;
    logic                      r_out_last, n_out_last;

    logic [TAG_BITS-1:0]  r_p_tag  [PORTS];
    logic                 r_p_wr   [PORTS];
    logic [ADDR_BITS-1:0] r_p_addr [PORTS];
    logic [WORD_BITS-1:0] r_p_data [PORTS];
    logic [LW-1:0]        r_p_left [PORTS];

    // pending list controls
    logic                 p_add;
    logic [TAG_BITS-1:0]  p_add_tag;
    logic                 p_add_wr;
    logic [ADDR_BITS-1:0] p_add_addr;
    logic [WORD_BITS-1:0] p_add_data;
    logic                 p_rm;
    logic                 p_dec;

    logic                 em;
    logic [TAG_BITS-1:0]  em_tag;
    mlm_pkg::t_status     em_status;
    logic [WORD_BITS-1:0] em_data;

    logic                 lat1;
    logic                 can_assign;
    logic                 can_emit;
    logic                 q_full;
    logic                 scan_end;
    logic [PIDX_W-1:0]    pi;
    logic [LW-1:0]        left_dec;
    logic [CNT_W:0]       free_sum;
    logic [mlm_pkg::PC_W-1:0] cfg_pc;
    logic [CNT_W-1:0]     freed_inc;

    logic                 st_we;
    logic [WORD_BITS-1:0] st_rdata;
    logic                 q_we;
    logic [QE_W-1:0]      q_rdata;
    logic [TAG_BITS-1:0]  q_tag;
    logic                 q_wr;
    logic [ADDR_BITS-1:0] q_addr;
    logic [WORD_BITS-1:0] q_data;

    assign lat1       = (r_lat <= LW'(1));
    assign can_assign = (r_free != '0) && (lat1 || (r_pcnt < CNT_W'(PORTS)));
    assign can_emit   = !r_hold_v || !r_out_v;
    assign q_full     = (r_qcnt == QC_W'(QUEUE_DEPTH));
    assign scan_end   = (r_idx >= r_pcnt);
    assign pi         = r_idx[PIDX_W-1:0];
    assign left_dec   = (r_p_left[pi] == '0) ? '0 : r_p_left[pi] - LW'(1);
    assign free_sum   = {1'b0, r_free} + {1'b0, r_ret_ports};
    assign cfg_pc     = i_cfg_data[mlm_pkg::PC_W-1:0];
    assign freed_inc  = (r_freed < CNT_W'(PORTS)) ? r_freed + CNT_W'(1) : r_freed;
    assign q_tag      = q_rdata[TAG_BITS-1:0];
    assign q_data     = q_rdata[TAG_BITS +: WORD_BITS];
    assign q_addr     = q_rdata[TAG_BITS + WORD_BITS +: ADDR_BITS];
    assign q_wr       = q_rdata[QE_W-1];

    assign o_ready    = (r_state == mlm_pkg::S_IDLE);
    assign o_valid    = r_out_v;
    assign o_tag      = r_out_tag;
    assign o_status   = r_out_status;
    assign o_data     = r_out_data;
    assign o_last     = r_out_last;

    assign o_stat.busy        = (r_state != mlm_pkg::S_IDLE);
    assign o_stat.pend_count  = 4'(r_pcnt);
    assign o_stat.queue_count = 7'(r_qcnt);
    assign o_stat.free_ports  = 4'(r_free);

    mlm_ram #(.WIDTH(WORD_BITS), .DEPTH(1 << ADDR_BITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_srv_addr),
        .i_wdata (r_srv_data),
        .i_raddr (r_srv_addr),
        .o_rdata (st_rdata)
    );

    mlm_ram #(.WIDTH(QE_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_qtail),
        .i_wdata ({i_cmd == mlm_pkg::CMD_WRITE, i_addr, i_data, i_tag}),
        .i_raddr (r_qhead),
        .o_rdata (q_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlm_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd)
                        mlm_pkg::CMD_TICK:   n_state = mlm_pkg::S_TSCAN;
                        mlm_pkg::CMD_CANCEL: n_state = mlm_pkg::S_CSCAN;
                        default: begin
                            if (can_assign) begin
                                n_state = lat1 ? mlm_pkg::S_SERVE : mlm_pkg::S_FLUSH;
                            end else if (!q_full) begin
                                n_state = mlm_pkg::S_FLUSH;
                            end else begin
                                n_state = mlm_pkg::S_DROP;
                            end
                        end
                    endcase
                end
            end
            mlm_pkg::S_SERVE: begin
                if (!r_srv_wr) begin
                    n_state = mlm_pkg::S_SERVE_DATA;
                end else if (can_emit) begin
                    n_state = r_ret;
                end
            end
            mlm_pkg::S_SERVE_DATA: begin
                if (can_emit) begin
                    n_state = r_ret;
                end
            end
            mlm_pkg::S_DROP: begin
                if (can_emit) begin
                    n_state = mlm_pkg::S_FLUSH;
                end
            end
            mlm_pkg::S_TSCAN: begin
                if (scan_end) begin
                    n_state = mlm_pkg::S_QWAIT;
                end else if (left_dec == '0) begin
                    n_state = mlm_pkg::S_SERVE;
                end
            end
            mlm_pkg::S_QWAIT: n_state = mlm_pkg::S_QCHECK;
            mlm_pkg::S_QCHECK: begin
                if ((r_qcnt != '0) && can_assign) begin
                    n_state = lat1 ? mlm_pkg::S_SERVE : mlm_pkg::S_QWAIT;
                end else begin
                    n_state = mlm_pkg::S_FLUSH;
                end
            end
            mlm_pkg::S_CSCAN: begin
                if (scan_end || (r_p_tag[pi] == r_srv_tag)) begin
                    n_state = mlm_pkg::S_FLUSH;
                end
            end
            mlm_pkg::S_FLUSH: begin
                if (!r_hold_v || !r_out_v) begin
                    n_state = mlm_pkg::S_IDLE;
                end
            end
            default: n_state = mlm_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_ret       = r_ret;
        n_idx       = r_idx;
        n_srv_tag   = r_srv_tag;
        n_srv_wr    = r_srv_wr;
        n_srv_addr  = r_srv_addr;
        n_srv_data  = r_srv_data;
        n_ret_ports = r_ret_ports;
        n_free      = r_free;
        n_freed     = r_freed;
        n_lat       = r_lat;
        n_qhead     = r_qhead;
        n_qtail     = r_qtail;
        n_qcnt      = r_qcnt;
        p_add       = 1'b0;
        p_add_tag   = r_srv_tag;
        p_add_wr    = r_srv_wr;
        p_add_addr  = r_srv_addr;
        p_add_data  = r_srv_data;
        p_rm        = 1'b0;
        p_dec       = 1'b0;
        em          = 1'b0;
        em_tag      = r_srv_tag;
        em_status   = mlm_pkg::ST_READ;
        em_data     = '0;
        st_we       = 1'b0;
        q_we        = 1'b0;
        n_hold_v      = r_hold_v;
        n_hold_tag    = r_hold_tag;
        n_hold_status = r_hold_status;
        n_hold_data   = r_hold_data;
        n_out_v       = r_out_v && !i_ready;
        n_out_tag     = r_out_tag;
        n_out_status  = r_out_status;
        n_out_data    = r_out_data;
        n_out_last    = r_out_last;

        case (r_state)
            mlm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_srv_tag  = i_tag;
                    n_srv_wr   = (i_cmd == mlm_pkg::CMD_WRITE);
                    n_srv_addr = i_addr;
                    n_srv_data = i_data;
                    n_idx      = '0;
                    case (i_cmd)
                        mlm_pkg::CMD_TICK: begin
                            n_ret_ports = r_freed;
                            n_freed     = '0;
                        end
                        mlm_pkg::CMD_CANCEL: begin
                            n_idx = '0;
                        end
                        default: begin
                            if (can_assign) begin
                                n_free = r_free - CNT_W'(1);
                                n_ret  = mlm_pkg::S_FLUSH;
                                if (!lat1) begin
                                    p_add      = 1'b1;
                                    p_add_tag  = i_tag;
                                    p_add_wr   = (i_cmd == mlm_pkg::CMD_WRITE);
                                    p_add_addr = i_addr;
                                    p_add_data = i_data;
                                end
                            end else if (!q_full) begin
                                q_we    = 1'b1;
                                n_qtail = (r_qtail == QA_W'(QUEUE_DEPTH - 1)) ?
                                          '0 : r_qtail + QA_W'(1);
                                n_qcnt  = r_qcnt + QC_W'(1);
                            end
                        end
                    endcase
                end
            end
            mlm_pkg::S_SERVE: begin
                if (r_srv_wr && can_emit) begin
                    st_we     = 1'b1;
                    em        = 1'b1;
                    em_status = mlm_pkg::ST_WACK;
                    n_freed   = freed_inc;
                end
            end
            mlm_pkg::S_SERVE_DATA: begin
                if (can_emit) begin
                    em        = 1'b1;
                    em_status = mlm_pkg::ST_READ;
                    em_data   = st_rdata;
                    n_freed   = freed_inc;
                end
            end
            mlm_pkg::S_DROP: begin
                if (can_emit) begin
                    em        = 1'b1;
                    em_status = mlm_pkg::ST_DROP;
                end
            end
            mlm_pkg::S_TSCAN: begin
                if (scan_end) begin
                    n_free = (free_sum > (CNT_W+1)'(PORTS)) ?
                             CNT_W'(PORTS) : free_sum[CNT_W-1:0];
                end else if (left_dec == '0) begin
                    n_srv_tag  = r_p_tag[pi];
                    n_srv_wr   = r_p_wr[pi];
                    n_srv_addr = r_p_addr[pi];
                    n_srv_data = r_p_data[pi];
                    p_rm       = 1'b1;
                    n_ret      = mlm_pkg::S_TSCAN;
                end else begin
                    p_dec = 1'b1;
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            mlm_pkg::S_QCHECK: begin
                if ((r_qcnt != '0) && can_assign) begin
                    n_qhead = (r_qhead == QA_W'(QUEUE_DEPTH - 1)) ?
                              '0 : r_qhead + QA_W'(1);
                    n_qcnt  = r_qcnt - QC_W'(1);
                    n_free  = r_free - CNT_W'(1);
                    if (lat1) begin
                        n_srv_tag  = q_tag;
                        n_srv_wr   = q_wr;
                        n_srv_addr = q_addr;
                        n_srv_data = q_data;
                        n_ret      = mlm_pkg::S_QWAIT;
                    end else begin
                        p_add      = 1'b1;
                        p_add_tag  = q_tag;
                        p_add_wr   = q_wr;
                        p_add_addr = q_addr;
                        p_add_data = q_data;
                    end
                end
            end
            mlm_pkg::S_CSCAN: begin
                if (!scan_end) begin
                    if (r_p_tag[pi] == r_srv_tag) begin
                        p_rm    = 1'b1;
                        n_freed = freed_inc;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            mlm_pkg::S_FLUSH: begin
                if (r_hold_v && !r_out_v) begin
                    n_out_v      = 1'b1;
                    n_out_tag    = r_hold_tag;
                    n_out_status = r_hold_status;
                    n_out_data   = r_hold_data;
                    n_out_last   = 1'b1;
                    n_hold_v     = 1'b0;
                end
            end
            default: ;
        endcase

        // a new result pushes the held one out as not last
        if (em) begin
            if (r_hold_v) begin
                n_out_v      = 1'b1;
                n_out_tag    = r_hold_tag;
                n_out_status = r_hold_status;
                n_out_data   = r_hold_data;
                n_out_last   = 1'b0;
            end
            n_hold_v      = 1'b1;
            n_hold_tag    = em_tag;
            n_hold_status = em_status;
            n_hold_data   = em_data;
        end

        if (i_cfg_we) begin
            case (mlm_pkg::t_cfg_index'(i_cfg_index))
                mlm_pkg::CFG_LATENCY:    n_lat = i_cfg_data[LW-1:0];
                mlm_pkg::CFG_PORT_COUNT: begin
                    n_free = ({1'b0, cfg_pc} > (mlm_pkg::PC_W+1)'(PORTS)) ?
                             CNT_W'(PORTS) : CNT_W'(cfg_pc);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlm_pkg::S_IDLE;
            r_ret       <= mlm_pkg::S_FLUSH;
            r_idx       <= '0;
            r_ret_ports <= '0;
            r_free      <= CNT_W'(PORTS);
            r_freed     <= '0;
            r_lat       <= LW'(1);
            r_pcnt      <= '0;
            r_qhead     <= '0;
            r_qtail     <= '0;
            r_qcnt      <= '0;
            r_hold_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_idx       <= n_idx;
            r_ret_ports <= n_ret_ports;
            r_free      <= n_free;
            r_freed     <= n_freed;
            r_lat       <= n_lat;
            r_qhead     <= n_qhead;
            r_qtail     <= n_qtail;
            r_qcnt      <= n_qcnt;
            r_hold_v    <= n_hold_v;
            r_out_v     <= n_out_v;
            if (p_add) begin
                r_pcnt <= r_pcnt + CNT_W'(1);
            end else if (p_rm) begin
                r_pcnt <= r_pcnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_srv_tag     <= n_srv_tag;
        r_srv_wr      <= n_srv_wr;
        r_srv_addr    <= n_srv_addr;
        r_srv_data    <= n_srv_data;
        r_hold_tag    <= n_hold_tag;
        r_hold_status <= n_hold_status;
        r_hold_data   <= n_hold_data;
        r_out_tag     <= n_out_tag;
        r_out_status  <= n_out_status;
        r_out_data    <= n_out_data;
        r_out_last    <= n_out_last;
    end

    // pending list: append at the end, remove by shifting down
    always_ff @(posedge i_clk) begin
        if (p_add) begin
            r_p_tag[r_pcnt[PIDX_W-1:0]]  <= p_add_tag;
            r_p_wr[r_pcnt[PIDX_W-1:0]]   <= p_add_wr;
            r_p_addr[r_pcnt[PIDX_W-1:0]] <= p_add_addr;
            r_p_data[r_pcnt[PIDX_W-1:0]] <= p_add_data;
            r_p_left[r_pcnt[PIDX_W-1:0]] <= r_lat - LW'(1);
        end else if (p_dec) begin
            r_p_left[pi] <= left_dec;
        end else if (p_rm) begin
            for (int k = 0; k < PORTS - 1; k++) begin
                if (k >= int'(pi)) begin
                    r_p_tag[k]  <= r_p_tag[k+1];
                    r_p_wr[k]   <= r_p_wr[k+1];
                    r_p_addr[k] <= r_p_addr[k+1];
                    r_p_data[k] <= r_p_data[k+1];
                    r_p_left[k] <= r_p_left[k+1];
                end
            end
        end
    end

endmodule

/* rtl/multiport_latency_memory_top.sv */
// Multiport fixed latency memory: a request stream in, a result stream out.
// A request served at once passes the front queue, the serve state and the hold register;
// a read adds the registered store read. A tick walks the pending list and serves entries
// whose wait has run out, then moves queued requests to pending or serves them.
// One item at a time passes the engine; a two-entry queue buffers intake.
// Reset is synchronous, active low, and clears control state; memories are not cleared.
`timescale 1ns / 1ps
`include "multiport_latency_memory_top_defines.svh"
module multiport_latency_memory_top #(
    parameter int PORTS       = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int ADDR_BITS   = 10,
    parameter int WORD_BITS   = 32,
    parameter int TAG_BITS    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [mlm_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // request_tag, address, write_data
    input  logic [((TAG_BITS+ADDR_BITS+WORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // command
    input  logic [mlm_pkg::CMD_W-1:0]  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // response_tag, read_data
    output logic [((TAG_BITS+WORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // status
    output logic [mlm_pkg::STAT_W-1:0] o_m_axis_tuser,
    output logic                       o_m_axis_tlast
);

    localparam int OUT_W = ((TAG_BITS + WORD_BITS + 7) / 8) * 8;

    logic                 f_valid;
    logic                 f_ready;
    mlm_pkg::t_cmd        f_cmd;
    logic [TAG_BITS-1:0]  f_tag;
    logic [ADDR_BITS-1:0] f_addr;
    logic [WORD_BITS-1:0] f_data;
    logic [TAG_BITS-1:0]  b_tag;
    mlm_pkg::t_status     b_status;
    logic [WORD_BITS-1:0] b_data;
    mlm_pkg::t_back_stat  b_stat;
    logic                 pend_over;
    logic                 queue_over;

    mlm_front #(.TAG_BITS(TAG_BITS), .ADDR_BITS(ADDR_BITS), .WORD_BITS(WORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_cmd   (i_s_axis_tuser),
        .i_tag   (i_s_axis_tdata[TAG_BITS-1:0]),
        .i_addr  (i_s_axis_tdata[TAG_BITS +: ADDR_BITS]),
        .i_data  (i_s_axis_tdata[TAG_BITS + ADDR_BITS +: WORD_BITS]),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cmd   (f_cmd),
        .o_tag   (f_tag),
        .o_addr  (f_addr),
        .o_data  (f_data)
    );

    mlm_back #(
        .PORTS       (PORTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_BITS   (ADDR_BITS),
        .WORD_BITS   (WORD_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (f_valid),
        .o_ready     (f_ready),
        .i_cmd       (f_cmd),
        .i_tag       (f_tag),
        .i_addr      (f_addr),
        .i_data      (f_data),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_tag       (b_tag),
        .o_status    (b_status),
        .o_data      (b_data),
        .o_last      (o_m_axis_tlast),
        .o_stat      (b_stat)
    );

    assign o_m_axis_tdata = OUT_W'({b_data, b_tag});
    assign o_m_axis_tuser = b_status;

    assign pend_over  = (int'(b_stat.pend_count) > PORTS);
    assign queue_over = (int'(b_stat.queue_count) > QUEUE_DEPTH);

    `MLM_ASSERT_NEVER(a_pend_bound, i_clk, i_rst_n, pend_over, "pending list overflow")
    `MLM_ASSERT_NEVER(a_queue_bound, i_clk, i_rst_n, queue_over, "wait queue overflow")
    `MLM_ASSERT_IMPL(a_take_idle, i_clk, i_rst_n, f_ready, !b_stat.busy, "engine took a request while busy")

endmodule
